### hw/rtl/indexed_sequence_store_top_macros.svh
// assertion macros shared by the rtl files
`ifndef INDEXED_SEQUENCE_STORE_TOP_MACROS_SVH
`define INDEXED_SEQUENCE_STORE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define ISS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ISS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ISS_ASSERT(lbl, prop, msg)
`define ISS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hw/rtl/iss_pkg.sv
package iss_pkg;

    localparam int ISS_CAPACITY = 64;
    localparam int DATA_W       = 32;
    localparam int CW           = 7;

    localparam logic [2:0] OP_READ      = 3'd0;
    localparam logic [2:0] OP_INS_FRONT = 3'd1;
    localparam logic [2:0] OP_APPEND    = 3'd2;
    localparam logic [2:0] OP_INS_AT    = 3'd3;
    localparam logic [2:0] OP_DELETE    = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic signed [DATA_W-1:0] NO_VALUE = '1;

    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [7:0]        position;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [1:0]               status;
        logic [CW-1:0]            count_now;
    } out_item_t;

    typedef enum logic [1:0] {
        K_NONE,
        K_INS,
        K_DEL
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load_req;
        logic setup;
        logic step;
        logic commit;
    } iss_cmd_t;

    typedef struct packed {
        logic do_shift;
        logic shift_done;
    } iss_stat_t;

endpackage

### hw/rtl/iss_datapath.sv
`include "indexed_sequence_store_top_macros.svh"

module iss_datapath
    import iss_pkg::*;
#(
    parameter int CAPACITY = ISS_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  iss_cmd_t  cmd,
    output iss_stat_t stat,
    output out_item_t out_data
);

    localparam int AW = $clog2(CAPACITY);

    logic [DATA_W-1:0] mem [CAPACITY];

    in_item_t          req_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    kind_t             kind_reg;
    logic              pend_reg;
    logic [1:0]        st_reg;
    logic              rd_ok_reg;
    logic [AW-1:0]     ins_pos_reg;
    logic [AW-1:0]     dst_reg;
    logic [AW-1:0]     wdst_reg;
    logic [CW-1:0]     moves_reg;
    logic [DATA_W-1:0] rd_data_reg;
    out_item_t         result_reg;

    logic              pos_neg;
    logic [CW-1:0]     pos_c;
    logic              full;
    logic              read_ok;
    logic              is_ins;
    logic              sel_valid;
    logic [CW-1:0]     sel_p;
    logic [1:0]        st;
    kind_t             kind;
    logic [CW-1:0]     moves;
    logic [AW-1:0]     start_dst;
    logic              more;
    logic [AW-1:0]     src;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              del_commit;

    assign pos_neg = req_reg.position[7];
    assign pos_c   = req_reg.position[CW-1:0];
    assign full    = (count_reg == CW'(CAPACITY));

    always_comb
    begin
        read_ok   = 1'b0;
        is_ins    = 1'b0;
        sel_valid = 1'b0;
        sel_p     = '0;
        st        = ST_DONE;
        kind      = K_NONE;
        case (req_reg.opcode)
            OP_READ:
            begin
                read_ok = !pos_neg && (pos_c < count_reg);
                st      = read_ok ? ST_DONE : ST_RANGE;
            end
            OP_INS_FRONT:
            begin
                is_ins    = 1'b1;
                sel_valid = 1'b1;
            end
            OP_APPEND:
            begin
                is_ins    = 1'b1;
                sel_valid = 1'b1;
                sel_p     = count_reg;
            end
            OP_INS_AT:
            begin
                is_ins    = 1'b1;
                sel_valid = !pos_neg && (pos_c <= count_reg);
                sel_p     = pos_c;
            end
            OP_DELETE:
            begin
                sel_valid = !pos_neg && (pos_c < count_reg);
                sel_p     = pos_c;
                if (sel_valid)
                begin
                    kind = K_DEL;
                end
                else
                begin
                    st = ST_RANGE;
                end
            end
            default:
            begin
                st = ST_DONE;
            end
        endcase
        if (is_ins)
        begin
            if (!sel_valid)
            begin
                st = ST_RANGE;
            end
            else if (full)
            begin
                st = ST_FULL;
            end
            else
            begin
                kind = K_INS;
            end
        end
    end

    // insert walks down from the tail, delete walks up from the hole
    always_comb
    begin
        if (kind == K_INS)
        begin
            moves     = count_reg - sel_p;
            start_dst = count_reg[AW-1:0];
        end
        else
        begin
            moves     = count_reg - CW'(1) - sel_p;
            start_dst = sel_p[AW-1:0];
        end
    end

    assign more = (moves_reg != '0);
    assign src  = (kind_reg == K_INS) ? (dst_reg - AW'(1)) : (dst_reg + AW'(1));

    assign rd_en   = (cmd.setup && read_ok) || (cmd.step && more);
    assign rd_addr = cmd.setup ? pos_c[AW-1:0] : src;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = wdst_reg;
        wr_data = rd_data_reg;
        if (cmd.step && pend_reg)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.commit && (kind_reg == K_INS))
        begin
            wr_en   = 1'b1;
            wr_addr = ins_pos_reg;
            wr_data = req_reg.value;
        end
    end

    always_comb
    begin
        case (kind_reg)
            K_INS:   count_next = count_reg + CW'(1);
            K_DEL:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            kind_reg  <= K_NONE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.step && more;
            if (cmd.setup)
            begin
                kind_reg <= kind;
            end
            if (cmd.commit)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= in_data;
        end
        if (cmd.setup)
        begin
            st_reg      <= st;
            rd_ok_reg   <= read_ok;
            ins_pos_reg <= sel_p[AW-1:0];
            dst_reg     <= start_dst;
            moves_reg   <= moves;
        end
        else if (cmd.step && more)
        begin
            wdst_reg  <= dst_reg;
            dst_reg   <= src;
            moves_reg <= moves_reg - CW'(1);
        end
        if (cmd.commit)
        begin
            result_reg.read_value <= rd_ok_reg ? rd_data_reg : NO_VALUE;
            result_reg.status     <= st_reg;
            result_reg.count_now  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign stat.do_shift   = (kind != K_NONE);
    assign stat.shift_done = !more && !pend_reg;
    assign out_data        = result_reg;

    assign del_commit = cmd.commit && (kind_reg == K_DEL);

    `ISS_ASSERT(a_count_bound, count_reg <= CW'(CAPACITY), "count above capacity")
    `ISS_ASSERT(a_pend_step, pend_reg |-> cmd.step, "pending move lost")
    `ISS_ASSERT(a_del_count, del_commit |=> count_reg == $past(count_reg) - CW'(1), "delete count")

endmodule

### hw/rtl/iss_ctrl.sv
`include "indexed_sequence_store_top_macros.svh"

module iss_ctrl
    import iss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  iss_stat_t stat,
    output iss_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.setup  = 1'b1;
                state_next = stat.do_shift ? S_SHIFT : S_FINISH;
            end
            S_SHIFT:
            begin
                if (stat.shift_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_FINISH:
            begin
                // result register must be free before the store is updated
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `ISS_ASSERT(a_accept_exec, cmd.load_req |=> state_reg == S_EXEC, "accept without execute")
    `ISS_ASSERT(a_shift_end, (state_reg == S_SHIFT) && stat.shift_done |=> state_reg == S_FINISH, "shift did not finish")
    `ISS_ASSERT(a_finish_free, (state_reg == S_FINISH) && !out_valid_reg |=> out_valid_reg && (state_reg == S_IDLE), "result not issued")

endmodule

### hw/rtl/indexed_sequence_store_top.sv
// Ordered store of up to CAPACITY signed 32-bit values, one result per request. A read, a
// rejected request or an unknown opcode goes from setup straight to the result; an insert
// or delete that moves k entries passes through a shift phase first, in which the element
// memory shifts one entry per cycle, reading one entry while writing the one behind it (k
// is at most the current count). One request is worked on at a time; the next is taken
// while the previous result waits in the output register, and a result that is still
// waiting there holds back the store update of the request after it.
module indexed_sequence_store_top
    import iss_pkg::*;
#(
    parameter int CAPACITY = ISS_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    iss_cmd_t  cmd;
    iss_stat_t stat;

    iss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    iss_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule
